// ===== hdl/capg_pkg.sv =====
// ----------------------------------------------------------------------------
// capg_pkg
// Types and constants shared by the arc point generator modules.
// ----------------------------------------------------------------------------
package capg_pkg;

	// Field and register widths
	localparam int unsigned PIX_W      = 12;
	localparam int unsigned CENTRE_W   = 16;
	localparam int unsigned DIM_W      = 13;
	localparam int unsigned SHIFT_W    = 4;
	localparam int unsigned OFFSET_W   = 32;
	localparam int unsigned STEP_W     = 15;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 13;

	// Item function codes
	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_STEP  = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SHIFT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

	// Register reset values
	localparam logic [SHIFT_W-1:0] SHIFT_RST  = 4'd11;
	localparam logic [DIM_W-1:0]   WIDTH_RST  = 13'd512;
	localparam logic [DIM_W-1:0]   HEIGHT_RST = 13'd128;

	// Input item
	typedef struct packed {
		logic                       func;
		logic [PIX_W-1:0]           begin_x;
		logic [PIX_W-1:0]           begin_y;
		logic signed [CENTRE_W-1:0] center_x;
		logic signed [CENTRE_W-1:0] center_y;
	} capg_in_t;

	// Result item
	typedef struct packed {
		logic             point_valid;
		logic [PIX_W-1:0] point_x;
		logic [PIX_W-1:0] point_y;
		logic             arc_done;
		logic             start_rejected;
	} capg_out_t;

	// Effective configuration seen by the step logic
	typedef struct packed {
		logic [SHIFT_W-1:0] shift;   // 1..15
		logic [DIM_W-1:0]   width;   // clamped to the canvas cap
		logic [DIM_W-1:0]   height;
	} capg_cfg_t;

	// Arc state carried from item to item
	typedef struct packed {
		logic [OFFSET_W-1:0]        offset_x;
		logic [OFFSET_W-1:0]        offset_y;
		logic signed [CENTRE_W-1:0] centre_col;
		logic signed [CENTRE_W-1:0] centre_row;
		logic [DIM_W-1:0]           last_col;
		logic [DIM_W-1:0]           last_row;
		logic                       last_ok;   // a pixel was emitted this arc
		logic [STEP_W-1:0]          steps;
		logic                       active;
	} capg_state_t;

endpackage

// ===== hdl/capg_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// capg_cfg_regs
// Configuration registers and the effective shift and canvas size.
// ----------------------------------------------------------------------------
module capg_cfg_regs #(
	parameter int unsigned CANVAS_BITS = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [capg_pkg::CFG_IDX_W-1:0]      wr_index,
	input  logic [capg_pkg::CFG_DATA_W-1:0]     wr_data,
	output capg_pkg::capg_cfg_t                 cfg
);

	localparam logic [16:0] CAP = 17'd1 << CANVAS_BITS;

	logic [capg_pkg::SHIFT_W-1:0] shift_q;
	logic [capg_pkg::DIM_W-1:0]   width_q;
	logic [capg_pkg::DIM_W-1:0]   height_q;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q  <= capg_pkg::SHIFT_RST;
			width_q  <= capg_pkg::WIDTH_RST;
			height_q <= capg_pkg::HEIGHT_RST;
		end else if (wr_en) begin
			case (wr_index)
				capg_pkg::CFG_SHIFT:  shift_q  <= wr_data[capg_pkg::SHIFT_W-1:0];
				capg_pkg::CFG_WIDTH:  width_q  <= wr_data;
				capg_pkg::CFG_HEIGHT: height_q <= wr_data;
				default: ;
			endcase
		end
	end

	// Zero shift acts as one; dimensions clamp to the canvas cap
	always_comb begin
		cfg.shift  = (shift_q == '0) ? 4'd1 : shift_q;
		cfg.width  = ({4'd0, width_q} > CAP) ? CAP[capg_pkg::DIM_W-1:0] : width_q;
		cfg.height = ({4'd0, height_q} > CAP) ? CAP[capg_pkg::DIM_W-1:0] : height_q;
	end

endmodule

// ===== hdl/capg_step_core.sv =====
// ----------------------------------------------------------------------------
// capg_step_core
// Combinational start/step logic: pixel, bounds, dedup and rotation.
// ----------------------------------------------------------------------------
module capg_step_core (
	input  capg_pkg::capg_in_t    item,
	input  capg_pkg::capg_cfg_t   cfg,
	input  capg_pkg::capg_state_t st,
	output capg_pkg::capg_state_t st_next,
	output capg_pkg::capg_out_t   res
);

	logic [15:0]        limit;
	logic [15:0]        steps_inc;
	logic signed [31:0] asr_x;
	logic signed [31:0] asr_y;
	logic [33:0]        px;
	logic [33:0]        py;
	logic               px_on;
	logic               py_on;
	logic               same;
	logic               bx_ok;
	logic               by_ok;
	logic [17:0]        dx;
	logic [17:0]        dy;
	logic [31:0]        dx_w;
	logic [31:0]        dy_w;

	// Step limit and counter increment
	assign limit     = 16'd1 << (cfg.shift - 4'd1);
	assign steps_inc = {1'b0, st.steps} + 16'd1;

	// Current pixel: centre plus scaled-down offset (row axis points down)
	assign asr_x = $signed(st.offset_x) >>> cfg.shift;
	assign asr_y = $signed(st.offset_y) >>> cfg.shift;
	assign px = {{18{st.centre_col[15]}}, st.centre_col} + {{2{asr_x[31]}}, asr_x};
	assign py = {{18{st.centre_row[15]}}, st.centre_row} - {{2{asr_y[31]}}, asr_y};

	assign px_on = !px[33] && (px[32:0] < {20'd0, cfg.width});
	assign py_on = !py[33] && (py[32:0] < {20'd0, cfg.height});
	assign same  = st.last_ok && (px[12:0] == st.last_col) && (py[12:0] == st.last_row);

	// Start offsets, scaled up by the shift
	assign bx_ok = {1'b0, item.begin_x} < cfg.width;
	assign by_ok = {1'b0, item.begin_y} < cfg.height;
	assign dx    = {6'd0, item.begin_x} - {{2{item.center_x[15]}}, item.center_x};
	assign dy    = {{2{item.center_y[15]}}, item.center_y} - {6'd0, item.begin_y};
	assign dx_w  = {{14{dx[17]}}, dx} << cfg.shift;
	assign dy_w  = {{14{dy[17]}}, dy} << cfg.shift;

	// Next state and result
	always_comb begin
		st_next = st;
		res     = '0;
		case (item.func)
			capg_pkg::FUNC_START: begin
				if (bx_ok && by_ok) begin
					st_next.centre_col = item.center_x;
					st_next.centre_row = item.center_y;
					st_next.offset_x   = dx_w;
					st_next.offset_y   = dy_w;
					st_next.last_ok    = 1'b0;
					st_next.steps      = '0;
					st_next.active     = 1'b1;
				end else begin
					st_next.active     = 1'b0;
					res.arc_done       = 1'b1;
					res.start_rejected = 1'b1;
				end
			end
			capg_pkg::FUNC_STEP: begin
				if (!st.active || ({1'b0, st.steps} >= limit)) begin
					st_next.active = 1'b0;
					res.arc_done   = 1'b1;
				end else begin
					if (px_on && py_on && !same) begin
						res.point_valid  = 1'b1;
						res.point_x      = px[11:0];
						res.point_y      = py[11:0];
						st_next.last_ok  = 1'b1;
						st_next.last_col = px[12:0];
						st_next.last_row = py[12:0];
					end
					// Clockwise shift-and-add rotation, both from old values
					st_next.offset_y = st.offset_y - $unsigned(asr_x);
					st_next.offset_x = st.offset_x + $unsigned(asr_y);
					st_next.steps    = steps_inc[capg_pkg::STEP_W-1:0];
					if (steps_inc >= limit) begin
						st_next.active = 1'b0;
						res.arc_done   = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== hdl/circle_arc_point_generator_top.sv =====
// ----------------------------------------------------------------------------
// circle_arc_point_generator_top
// Path: input register, then result register, with the step stage between.
// Throughput: one item per cycle while the result register is not stalled by
// out_ready; the single step stage updating the arc state sets this rate.
// Reset: arst_n clears the pipeline, arc state (idle) and the registers to
// shift 11, canvas 512 x 128. The configuration port is always ready.
// ----------------------------------------------------------------------------
module circle_arc_point_generator_top #(
	parameter int unsigned CANVAS_BITS = 12
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  capg_pkg::capg_in_t              in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output capg_pkg::capg_out_t             out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [capg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [capg_pkg::CFG_DATA_W-1:0] cfg_data
);

	capg_pkg::capg_cfg_t   cfg;
	capg_pkg::capg_in_t    item_s1;
	logic                  valid_s1;
	capg_pkg::capg_state_t state_q;
	capg_pkg::capg_state_t state_next;
	capg_pkg::capg_out_t   res;
	capg_pkg::capg_out_t   out_q;
	logic                  out_valid_q;
	logic                  adv;

	assign cfg_ready = 1'b1;

	capg_cfg_regs #(
		.CANVAS_BITS(CANVAS_BITS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Stage 1 moves on when the result register is free or being drained
	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	capg_step_core u_core (
		.item    (item_s1),
		.cfg     (cfg),
		.st      (state_q),
		.st_next (state_next),
		.res     (res)
	);

	// Arc state commits once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv) begin
			state_q <= state_next;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef NO_ASSERTIONS
	// A rejected start ends the arc and emits no pixel
	a_reject_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.start_rejected |-> out_data.arc_done && !out_data.point_valid)
		else $error("rejected start without arc_done");

	// An arc_done result leaves the block idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res.arc_done |=> !state_q.active)
		else $error("arc still active after arc_done");

	// An accepted start restarts counting with no pixel remembered
	a_start_clear: assert property (@(posedge clk) disable iff (!arst_n)
		adv && (item_s1.func == capg_pkg::FUNC_START) && !res.start_rejected
		|=> state_q.active && (state_q.steps == '0) && !state_q.last_ok)
		else $error("start did not reset arc state");

	// An emitted pixel becomes the last pixel
	a_last_track: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res.point_valid
		|=> state_q.last_ok && (state_q.last_col[11:0] == $past(res.point_x))
			&& (state_q.last_row[11:0] == $past(res.point_y)))
		else $error("last pixel not updated");
`endif

endmodule
